[sv/cpre_pkg.sv]
// Shared constants for the column pairwise rate estimator.
// No dependencies; imported by every module of the block except cpre_ram.
`default_nettype none
package cpre_pkg;
    localparam int SYM_W = 8;
    localparam int NUM_W = 7;
    localparam int RATE_W = 21;
    localparam int CNT_OUT_W = 23;
    localparam int FRAC_W = 24;
    localparam int EXP_W = 6;
    localparam int LOG_W = EXP_W + FRAC_W;
    localparam int MUL_W = 64;
    localparam int MUL_B_W = 32;
    localparam int MANT_W = 32;
    localparam int DEF_MAX_STATES = 64;
    localparam int DEF_MAX_SEQUENCES = 4096;
    localparam logic [NUM_W-1:0] STATE_COUNT_RESET = 7'd4;
    localparam logic [MUL_W-1:0] LN2_Q32 = 64'h0000_0000_B172_17F8;
    localparam logic [RATE_W-1:0] RATE_MAX = 21'h1F_FFFF;
endpackage
`default_nettype wire

[sv/cpre_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module cpre_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[sv/cpre_accum.sv]
// Per-column symbol accumulation: state histogram in RAM plus pair counters.
// Depends on cpre_pkg and cpre_ram.
`default_nettype none
module cpre_accum
    import cpre_pkg::*;
#(
    parameter int MAX_STATES = DEF_MAX_STATES,
    parameter int MAX_SEQUENCES = DEF_MAX_SEQUENCES,
    localparam int ST_W = $clog2(MAX_STATES),
    localparam int CNT_W = $clog2(MAX_SEQUENCES + 1),
    localparam int PAIR_W = 2 * CNT_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [NUM_W-1:0]  n_eff,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [SYM_W-1:0]  symbol,
    input  wire logic              last,
    input  wire logic              calc_idle,
    output logic                   calc_start,
    output logic [PAIR_W-1:0]      diff_raw,
    output logic [PAIR_W-1:0]      total_raw
);
    typedef enum logic [1:0] {A_IDLE, A_UPD, A_HAND} acc_state_t;

    acc_state_t            state_reg;
    logic [ST_W-1:0]       idx_reg;
    logic                  hit_reg;
    logic                  last_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [PAIR_W-1:0]     total_reg;
    logic [PAIR_W-1:0]     mism_reg;
    logic [MAX_STATES-1:0] vbit_reg;
    logic [CNT_W-1:0]      rd_data;
    logic [CNT_W-1:0]      hist;
    logic                  hit;
    logic                  accept;

    assign in_ready = (state_reg == A_IDLE);
    assign accept = in_valid && in_ready;
    assign hit = ({1'b0, symbol} < {2'b00, n_eff}) && (cnt_reg < CNT_W'(MAX_SEQUENCES));
    assign hist = vbit_reg[idx_reg] ? rd_data : '0;
    assign calc_start = (state_reg == A_HAND) && calc_idle;
    assign diff_raw = mism_reg;
    assign total_raw = total_reg;

    cpre_ram #(
        .WIDTH(CNT_W),
        .DEPTH(MAX_STATES)
    ) u_hist (
        .clk  (clk),
        .we   ((state_reg == A_UPD) && hit_reg),
        .waddr(idx_reg),
        .wdata(hist + CNT_W'(1)),
        .re   (accept),
        .raddr(symbol[ST_W-1:0]),
        .rdata(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            hit_reg <= 1'b0;
            last_reg <= 1'b0;
            idx_reg <= '0;
            cnt_reg <= '0;
            total_reg <= '0;
            mism_reg <= '0;
            vbit_reg <= '0;
        end
        else
        begin
            case (state_reg)
                A_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg <= symbol[ST_W-1:0];
                        hit_reg <= hit;
                        last_reg <= last;
                        state_reg <= A_UPD;
                    end
                end
                A_UPD:
                begin
                    if (hit_reg)
                    begin
                        total_reg <= total_reg + PAIR_W'(cnt_reg);
                        mism_reg <= mism_reg + PAIR_W'(cnt_reg - hist);
                        vbit_reg[idx_reg] <= 1'b1;
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    state_reg <= last_reg ? A_HAND : A_IDLE;
                end
                A_HAND:
                begin
                    if (calc_idle)
                    begin
                        cnt_reg <= '0;
                        total_reg <= '0;
                        mism_reg <= '0;
                        vbit_reg <= '0;
                        state_reg <= A_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/cpre_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on cpre_pkg.
`default_nettype none
module cpre_mul
    import cpre_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [MUL_W-1:0]   a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic                    done,
    output logic [MUL_W-1:0]        prod
);
    localparam int STEP_W = $clog2(MUL_B_W);

    logic [MUL_W-1:0]   a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                a_reg <= a;
                b_reg <= b;
                prod <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                prod <= prod + (b_reg[0] ? a_reg : '0);
                a_reg <= {a_reg[MUL_W-2:0], 1'b0};
                b_reg <= {1'b0, b_reg[MUL_B_W-1:1]};
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MUL_B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

[sv/cpre_div.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on cpre_pkg.
`default_nettype none
module cpre_div
    import cpre_pkg::*;
#(
    parameter int DEN_W = 26
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [MUL_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [MUL_W-1:0]      quot
);
    localparam int STEP_W = $clog2(MUL_W);

    logic [MUL_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, num_reg[MUL_W-1]};
    assign fits = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                num_reg <= num;
                den_reg <= den;
                rem_reg <= '0;
                quot <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                quot <= {quot[MUL_W-2:0], fits};
                num_reg <= {num_reg[MUL_W-2:0], 1'b0};
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MUL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

[sv/cpre_calc.sv]
// Per-column rate computation: sequencer over the serial multiplier and divider.
// Depends on cpre_pkg, cpre_mul and cpre_div.
`default_nettype none
module cpre_calc
    import cpre_pkg::*;
#(
    parameter int PAIR_W = 26,
    localparam int DEN_W = (PAIR_W > NUM_W) ? PAIR_W : NUM_W,
    localparam int IT_W = $clog2(FRAC_W + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      idle,
    input  wire logic [PAIR_W-1:0]    diff_raw,
    input  wire logic [PAIR_W-1:0]    total_raw,
    input  wire logic [NUM_W-1:0]     n_eff,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [RATE_W-1:0]         rate_q16,
    output logic                      fallback_used,
    output logic                      rate_saturated,
    output logic [CNT_OUT_W-1:0]      mismatch_pairs,
    output logic [CNT_OUT_W-1:0]      valid_pairs
);
    typedef enum logic [3:0] {
        C_IDLE, C_MD, C_MA, C_NORM, C_SQ, C_MK, C_MT, C_DIVP, C_DIVN, C_OUT
    } calc_state_t;

    calc_state_t         state_reg;
    logic [NUM_W-1:0]    n_reg;
    logic [PAIR_W-1:0]   diff_reg;
    logic [PAIR_W-1:0]   total_reg;
    logic [MUL_W-1:0]    d_reg;
    logic [MUL_W-1:0]    nn_reg;
    logic [MUL_W-1:0]    sh_reg;
    logic [EXP_W-1:0]    e_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic [IT_W-1:0]     it_reg;
    logic                sel_reg;
    logic [LOG_W-1:0]    ld_reg;
    logic                mul_start_reg;
    logic [MUL_W-1:0]    mul_a_reg;
    logic [MUL_B_W-1:0]  mul_b_reg;
    logic                div_start_reg;
    logic [MUL_W-1:0]    div_num_reg;
    logic [DEN_W-1:0]    div_den_reg;
    logic                mul_done;
    logic [MUL_W-1:0]    prod;
    logic                div_done;
    logic [MUL_W-1:0]    quot;
    logic [MUL_W-MANT_W:0] sq;
    logic [LOG_W-1:0]    lcur;
    logic [LOG_W-1:0]    l_diff;
    logic [MUL_W-1:0]    rate_full;
    logic [PAIR_W+CNT_OUT_W-1:0] diff_ext;
    logic [PAIR_W+CNT_OUT_W-1:0] total_ext;
    logic [PAIR_W-1:0]   diff1;
    logic [PAIR_W-1:0]   total1;

    cpre_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mul_start_reg),
        .a    (mul_a_reg),
        .b    (mul_b_reg),
        .done (mul_done),
        .prod (prod)
    );

    cpre_div #(
        .DEN_W(DEN_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start_reg),
        .num  (div_num_reg),
        .den  (div_den_reg),
        .done (div_done),
        .quot (quot)
    );

    assign idle = (state_reg == C_IDLE);
    assign out_valid = (state_reg == C_OUT);
    assign sq = prod[MUL_W-1:MANT_W-1];
    assign lcur = {e_reg, frac_reg[FRAC_W-2:0], sq[MUL_W-MANT_W]};
    assign l_diff = (ld_reg > lcur) ? (ld_reg - lcur) : '0;
    assign rate_full = (state_reg == C_DIVP) ? quot : ((quot + MUL_W'(32768)) >> 16);
    assign diff_ext = {{CNT_OUT_W{1'b0}}, diff_reg};
    assign total_ext = {{CNT_OUT_W{1'b0}}, total_reg};
    assign mismatch_pairs = diff_ext[CNT_OUT_W-1:0];
    assign valid_pairs = total_ext[CNT_OUT_W-1:0];
    assign diff1 = (diff_reg == '0) ? PAIR_W'(1) : diff_reg;
    assign total1 = (total_reg == '0) ? PAIR_W'(1) : total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            sel_reg <= 1'b0;
            it_reg <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        diff_reg <= diff_raw;
                        total_reg <= total_raw;
                        n_reg <= n_eff;
                        mul_a_reg <= MUL_W'((total_raw == '0) ? PAIR_W'(1) : total_raw);
                        mul_b_reg <= MUL_B_W'(n_eff - NUM_W'(1));
                        mul_start_reg <= 1'b1;
                        state_reg <= C_MD;
                    end
                end
                C_MD:
                begin
                    if (mul_done)
                    begin
                        d_reg <= prod;
                        mul_a_reg <= MUL_W'(diff1);
                        mul_b_reg <= MUL_B_W'(n_reg);
                        mul_start_reg <= 1'b1;
                        state_reg <= C_MA;
                    end
                end
                C_MA:
                begin
                    if (mul_done)
                    begin
                        if (prod >= d_reg)
                        begin
                            fallback_used <= 1'b1;
                            div_num_reg <= (MUL_W'(diff1) << 16) + MUL_W'(total1 >> 1);
                            div_den_reg <= DEN_W'(total1);
                            div_start_reg <= 1'b1;
                            state_reg <= C_DIVP;
                        end
                        else
                        begin
                            fallback_used <= 1'b0;
                            nn_reg <= d_reg - prod;
                            sh_reg <= d_reg;
                            e_reg <= EXP_W'(MUL_W - 1);
                            sel_reg <= 1'b0;
                            state_reg <= C_NORM;
                        end
                    end
                end
                C_NORM:
                begin
                    if (sh_reg[MUL_W-1])
                    begin
                        mul_a_reg <= MUL_W'(sh_reg[MUL_W-1:MUL_W-MANT_W]);
                        mul_b_reg <= sh_reg[MUL_W-1:MUL_W-MANT_W];
                        mul_start_reg <= 1'b1;
                        frac_reg <= '0;
                        it_reg <= '0;
                        state_reg <= C_SQ;
                    end
                    else
                    begin
                        sh_reg <= {sh_reg[MUL_W-2:0], 1'b0};
                        e_reg <= e_reg - EXP_W'(1);
                    end
                end
                C_SQ:
                begin
                    if (mul_done)
                    begin
                        frac_reg <= {frac_reg[FRAC_W-2:0], sq[MUL_W-MANT_W]};
                        it_reg <= it_reg + IT_W'(1);
                        if (it_reg == IT_W'(FRAC_W - 1))
                        begin
                            if (!sel_reg)
                            begin
                                ld_reg <= lcur;
                                sel_reg <= 1'b1;
                                sh_reg <= nn_reg;
                                e_reg <= EXP_W'(MUL_W - 1);
                                state_reg <= C_NORM;
                            end
                            else
                            begin
                                mul_a_reg <= LN2_Q32;
                                mul_b_reg <= MUL_B_W'(l_diff);
                                mul_start_reg <= 1'b1;
                                state_reg <= C_MK;
                            end
                        end
                        else
                        begin
                            mul_a_reg <= MUL_W'(sq[MUL_W-MANT_W] ?
                                                sq[MUL_W-MANT_W:1] : sq[MANT_W-1:0]);
                            mul_b_reg <= sq[MUL_W-MANT_W] ? sq[MUL_W-MANT_W:1] : sq[MANT_W-1:0];
                            mul_start_reg <= 1'b1;
                        end
                    end
                end
                C_MK:
                begin
                    if (mul_done)
                    begin
                        mul_a_reg <= prod >> FRAC_W;
                        mul_b_reg <= MUL_B_W'(n_reg - NUM_W'(1));
                        mul_start_reg <= 1'b1;
                        state_reg <= C_MT;
                    end
                end
                C_MT:
                begin
                    if (mul_done)
                    begin
                        div_num_reg <= prod;
                        div_den_reg <= DEN_W'(n_reg);
                        div_start_reg <= 1'b1;
                        state_reg <= C_DIVN;
                    end
                end
                C_DIVP, C_DIVN:
                begin
                    if (div_done)
                    begin
                        if (rate_full > MUL_W'(RATE_MAX))
                        begin
                            rate_q16 <= RATE_MAX;
                            rate_saturated <= 1'b1;
                        end
                        else
                        begin
                            rate_q16 <= rate_full[RATE_W-1:0];
                            rate_saturated <= 1'b0;
                        end
                        state_reg <= C_OUT;
                    end
                end
                C_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= C_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/column_pairwise_rate_estimate.sv]
// Column pairwise rate estimator (Jukes-Cantor corrected mismatch rate).
// Symbols: each transaction reads the histogram RAM, then updates it; no new symbol is
// accepted during the update. Column end: the bit-serial multiplier forms two products
// and the bit-serial divider returns the raw proportion; the logarithm path adds 48
// squarings and two more products before its division. The next column streams while the
// result is computed, but after its last symbol the hand-off waits, with no new symbol
// accepted, until the previous result is taken. Reset clears all control state and sets the
// state count register to 4; the histogram needs no clearing pass.
`default_nettype none
module column_pairwise_rate_estimate
    import cpre_pkg::*;
#(
    parameter int MAX_STATES = DEF_MAX_STATES,
    parameter int MAX_SEQUENCES = DEF_MAX_SEQUENCES
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [NUM_W-1:0]     cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [SYM_W-1:0]     symbol,
    input  wire logic                 last,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [RATE_W-1:0]         rate_q16,
    output logic                      fallback_used,
    output logic                      rate_saturated,
    output logic [CNT_OUT_W-1:0]      mismatch_pairs,
    output logic [CNT_OUT_W-1:0]      valid_pairs
);
    localparam int PAIR_W = 2 * $clog2(MAX_SEQUENCES + 1);

    logic [NUM_W-1:0]  state_count_reg;
    logic [NUM_W-1:0]  n_eff;
    logic              calc_idle;
    logic              calc_start;
    logic [PAIR_W-1:0] diff_raw;
    logic [PAIR_W-1:0] total_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg <= STATE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            state_count_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (state_count_reg < NUM_W'(2))
        begin
            n_eff = NUM_W'(2);
        end
        else if (int'(state_count_reg) > MAX_STATES)
        begin
            n_eff = NUM_W'(MAX_STATES);
        end
        else
        begin
            n_eff = state_count_reg;
        end
    end

    cpre_accum #(
        .MAX_STATES   (MAX_STATES),
        .MAX_SEQUENCES(MAX_SEQUENCES)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .n_eff     (n_eff),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .symbol    (symbol),
        .last      (last),
        .calc_idle (calc_idle),
        .calc_start(calc_start),
        .diff_raw  (diff_raw),
        .total_raw (total_raw)
    );

    cpre_calc #(
        .PAIR_W(PAIR_W)
    ) u_calc (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (calc_start),
        .idle          (calc_idle),
        .diff_raw      (diff_raw),
        .total_raw     (total_raw),
        .n_eff         (n_eff),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rate_q16      (rate_q16),
        .fallback_used (fallback_used),
        .rate_saturated(rate_saturated),
        .mismatch_pairs(mismatch_pairs),
        .valid_pairs   (valid_pairs)
    );
endmodule
`default_nettype wire
